### src/polyblep_oscillator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyblep oscillator
// Implication forms with an active-high reset disable.
// ----------------------------------------------------------------------------
`ifndef POLYBLEP_OSCILLATOR_MACROS_SVH
`define POLYBLEP_OSCILLATOR_MACROS_SVH

// same-cycle implication
`define PBLOSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pblosc assertion failed");

// next-cycle implication
`define PBLOSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pblosc assertion failed");

`endif

### src/pblosc_pkg.sv
// ----------------------------------------------------------------------------
// pblosc_pkg
// Widths, codes, control structs and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pblosc_pkg;

  localparam int PHASE_BITS     = 24;
  localparam int STEP_BITS      = 23;
  localparam int SAMPLE_BITS    = 18;
  localparam int FRAC_BITS      = 32;               // Q0.32 cycle fraction
  localparam int PHASE_SHIFT    = FRAC_BITS - PHASE_BITS;
  localparam int ACC_BITS       = FRAC_BITS + 4;    // Q32 waveform sum
  localparam int BLEP_BITS      = FRAC_BITS + 2;    // correction, +/-1.0 in Q32
  localparam int OUT_FRAC_BITS  = 15;
  localparam int RND_SHIFT      = FRAC_BITS - OUT_FRAC_BITS;
  localparam int CNT_BITS       = $clog2(FRAC_BITS);
  localparam int CFG_DATA_BITS  = STEP_BITS;
  localparam int CFG_INDEX_BITS = 1;

  localparam int SINE_DEPTH     = 256;
  localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
  localparam int SINE_ADDR_BITS = SINE_IDX_BITS + 1;
  localparam int SINE_VAL_BITS  = 16;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor term divisors (2k)(2k+1) as rounded-up 2^48 reciprocals;
  // exact floor for any dividend below 2^40
  localparam int RCP_SHIFT = 48;
  localparam longint unsigned RCP_6   = ((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6;
  localparam longint unsigned RCP_20  = ((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20;
  localparam longint unsigned RCP_42  = ((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42;
  localparam longint unsigned RCP_72  = ((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72;
  localparam longint unsigned RCP_110 = ((64'd1 << RCP_SHIFT) + 64'd109) / 64'd110;
  localparam longint unsigned RCP_156 = ((64'd1 << RCP_SHIFT) + 64'd155) / 64'd156;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WAVEFORM   = 1'b0,
    CFG_PHASE_STEP = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_START,
    S_WAIT,
    S_ROUND,
    S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_CALC,
    B_DONE
  } blep_state_t;

  typedef struct packed {
    logic                 start;
    logic [FRAC_BITS-1:0] arg;
  } blep_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } blep_sts_t;

  typedef logic [SINE_VAL_BITS-1:0] sine_table_t [0:SINE_DEPTH];

  // sin(pi/2 * i/DEPTH), Taylor series to x^13 in Q30, rounded to Q15
  function automatic sine_table_t build_sine_table();
    sine_table_t       tbl;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   rcp;
    logic [127:0]      prod;
    int                i;
    int                k;
    for (i = 0; i <= SINE_DEPTH; i++) begin
      x    = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
      term = x;
      sum  = x;
      for (k = 1; k <= 6; k++) begin
        unique case (k)
          1:       rcp = RCP_6;
          2:       rcp = RCP_20;
          3:       rcp = RCP_42;
          4:       rcp = RCP_72;
          5:       rcp = RCP_110;
          default: rcp = RCP_156;
        endcase
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        prod = 128'(term) * 128'(rcp);
        term = prod[RCP_SHIFT+63:RCP_SHIFT];
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      tbl[i] = SINE_VAL_BITS'((sum + 64'd16384) >> 15);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

### src/pblosc_ifs.sv
// ----------------------------------------------------------------------------
// pblosc channel interfaces
// Valid/ready channels for phase commands and output samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pblosc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                restart;
  logic [pblosc_pkg::PHASE_BITS-1:0]   start_phase;

  modport source (output valid, output restart, output start_phase, input ready);
  modport sink   (input valid, input restart, input start_phase, output ready);
endinterface

interface pblosc_result_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pblosc_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### src/pblosc_blep.sv
// ----------------------------------------------------------------------------
// pblosc_blep
// Bit-serial PolyBLEP correction: restoring divide, then shift-add square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyblep_oscillator_macros.svh"

module pblosc_blep (
  input  logic                                        clk,
  input  logic                                        rst,
  input  pblosc_pkg::blep_req_t                       req,
  input  logic [pblosc_pkg::FRAC_BITS-1:0]            dt,
  output pblosc_pkg::blep_sts_t                       sts,
  output logic signed [pblosc_pkg::BLEP_BITS-1:0]     corr
);

  localparam int FB = pblosc_pkg::FRAC_BITS;
  localparam logic [FB:0] ONE_EXT = {1'b1, {FB{1'b0}}};
  localparam logic [pblosc_pkg::CNT_BITS-1:0] CNT_LAST = pblosc_pkg::CNT_BITS'(FB - 1);

  pblosc_pkg::blep_state_t state, state_next;

  logic [FB-2:0]                 rem;     // always below dt, which is below half
  logic [FB-1:0]                 quo;
  logic [FB-1:0]                 mreg;
  logic [FB-1:0]                 acc;
  logic [pblosc_pkg::CNT_BITS-1:0] cnt;
  logic                          hi;

  logic [FB:0]   hi_bound;
  logic [FB:0]   wrap_dist;
  logic          in_lo;
  logic          in_hi;
  logic [FB-1:0] rem2;
  logic [FB-1:0] rem_sub;
  logic          ge;
  logic [FB:0]   mac;
  logic signed [FB+2:0] blep_lo;

  // region test: t < dt, or t > 1 - dt
  assign hi_bound  = ONE_EXT - {1'b0, dt};
  assign wrap_dist = ONE_EXT - {1'b0, req.arg};
  assign in_lo     = req.arg < dt;
  assign in_hi     = {1'b0, req.arg} > hi_bound;

  assign rem2     = {rem, 1'b0};
  assign ge       = rem2 >= dt;
  assign rem_sub  = rem2 - dt;

  // high half of q*q, one multiplier bit per cycle
  assign mac      = {1'b0, acc} + (mreg[0] ? {1'b0, quo} : {(FB+1){1'b0}});

  // 2x - x^2 - 1 ; the high region gives the negation
  assign blep_lo  = $signed({2'b00, quo, 1'b0}) - $signed({3'b000, acc})
                  - $signed({2'b00, ONE_EXT});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pblosc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sts.busy   = (state != pblosc_pkg::B_IDLE);
    sts.done   = (state == pblosc_pkg::B_DONE);
    unique case (state)
      pblosc_pkg::B_IDLE: begin
        if (req.start) begin
          state_next = (in_lo || in_hi) ? pblosc_pkg::B_DIV : pblosc_pkg::B_DONE;
        end
      end
      pblosc_pkg::B_DIV: begin
        if (cnt == CNT_LAST) state_next = pblosc_pkg::B_MUL;
      end
      pblosc_pkg::B_MUL: begin
        if (cnt == CNT_LAST) state_next = pblosc_pkg::B_CALC;
      end
      pblosc_pkg::B_CALC: state_next = pblosc_pkg::B_DONE;
      pblosc_pkg::B_DONE: state_next = pblosc_pkg::B_IDLE;
      default:            state_next = pblosc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pblosc_pkg::B_IDLE: begin
        if (req.start) begin
          cnt  <= '0;
          hi   <= !in_lo;
          corr <= '0;
          rem  <= in_lo ? req.arg[FB-2:0] : wrap_dist[FB-2:0];
        end
      end
      pblosc_pkg::B_DIV: begin
        rem  <= ge ? rem_sub[FB-2:0] : rem2[FB-2:0];
        quo  <= {quo[FB-2:0], ge};
        mreg <= {quo[FB-2:0], ge};
        acc  <= '0;
        cnt  <= cnt + 1'b1;
      end
      pblosc_pkg::B_MUL: begin
        acc  <= mac[FB:1];
        mreg <= mreg >> 1;
        cnt  <= cnt + 1'b1;
      end
      pblosc_pkg::B_CALC: begin
        corr <= hi ? pblosc_pkg::BLEP_BITS'(-blep_lo) : pblosc_pkg::BLEP_BITS'(blep_lo);
      end
      default: ;
    endcase
  end

  `PBLOSC_ASSERT_NEXT(a_start_leaves_idle, clk, rst,
                      state == pblosc_pkg::B_IDLE && req.start, state != pblosc_pkg::B_IDLE)
  `PBLOSC_ASSERT_IMPL(a_rem_below_dt, clk, rst, state == pblosc_pkg::B_DIV, FB'(rem) < dt)
  `PBLOSC_ASSERT_NEXT(a_done_single, clk, rst, sts.done, !sts.done && !sts.busy)

endmodule

### src/polyblep_oscillator.sv
// ----------------------------------------------------------------------------
// polyblep_oscillator
// One oscillator voice: sine, triangle, PolyBLEP sawtooth and square.
//
// cmd (sink): one transaction per sample; restart=1 loads start_phase first.
// result (source): one signed Q2.15 sample per cmd transaction, in order.
// cfg_we/cfg_index/cfg_data: register writes, only while the voice is idle.
//   index 0 waveform (0 sine, 1 triangle, 2 sawtooth, 3 square),
//   index 1 phase_step (cycle fraction per sample).
// Sine goes straight to the output, triangle through the rounding step,
// sawtooth also through the wrap correction, square through the wrap and
// half-cycle corrections (each that applies runs the bit-serial divider,
// then the squarer). A new cmd is taken only after the current sample
// reaches the output register. The finished sample sits in that register,
// so cmd is ready again while it waits; a stalled receiver only holds the
// voice when the next sample is done and the register is still full.
// Reset: phase 0, waveform sine, phase_step 1, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyblep_oscillator_macros.svh"

module polyblep_oscillator (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [pblosc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pblosc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  pblosc_cmd_if.sink                                cmd,
  pblosc_result_if.source                           result
);

  localparam int PB = pblosc_pkg::PHASE_BITS;
  localparam int FB = pblosc_pkg::FRAC_BITS;
  localparam int AB = pblosc_pkg::ACC_BITS;
  localparam int SB = pblosc_pkg::SAMPLE_BITS;
  localparam int SW = AB - pblosc_pkg::RND_SHIFT;   // rounded width, one over SB

  localparam logic signed [AB-1:0] ONE_Q32 =
    {{(AB-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [AB-1:0] ROUND_BIAS =
    {{(AB-pblosc_pkg::RND_SHIFT){1'b0}}, 1'b1, {(pblosc_pkg::RND_SHIFT-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  // control
  pblosc_pkg::top_state_t state, state_next;
  pblosc_pkg::wave_t      waveform;
  logic [pblosc_pkg::STEP_BITS-1:0] phase_step;
  logic [PB-1:0]          phase_acc;
  logic                   load_out;
  logic                   accept;

  // working registers for the current sample
  logic [PB-1:0]          cur;
  logic signed [AB-1:0]   v;             // waveform in Q32
  logic signed [SB-1:0]   res;
  logic [FB-1:0]          blep_arg;
  logic                   sub;           // subtract this correction
  logic                   pending;       // square still owes the half-cycle edge

  pblosc_pkg::blep_req_t  blep_req;
  pblosc_pkg::blep_sts_t  blep_sts;
  logic signed [pblosc_pkg::BLEP_BITS-1:0] blep_corr;

  // phase and waveform arithmetic
  logic [PB-1:0]          p_sel;
  logic [FB-1:0]          t_cur;
  logic [FB-1:0]          ts;
  logic [FB-1:0]          dt;
  logic signed [AB-1:0]   d;
  logic signed [AB-1:0]   d_abs;
  logic signed [AB-1:0]   tri_v;
  logic signed [AB-1:0]   sq_v;
  logic signed [AB-1:0]   corr_ext;
  logic signed [AB-1:0]   rounded;
  logic signed [SW-1:0]   s_wide;
  logic signed [SB-1:0]   sat_s;

  // sine lookup
  logic [1:0]                              quad;
  logic [pblosc_pkg::SINE_IDX_BITS-1:0]    sidx;
  logic [pblosc_pkg::SINE_ADDR_BITS-1:0]   saddr;
  logic [pblosc_pkg::SINE_VAL_BITS-1:0]    sval;
  logic signed [SB-1:0]                    sine_pos;
  logic signed [SB-1:0]                    sine_s;

  assign accept = cmd.valid && cmd.ready;
  assign p_sel  = cmd.restart ? cmd.start_phase : phase_acc;

  assign t_cur  = {cur, {pblosc_pkg::PHASE_SHIFT{1'b0}}};
  assign ts     = {~t_cur[FB-1], t_cur[FB-2:0]};    // t + 1/2, wrapped
  assign dt     = {{(PB-pblosc_pkg::STEP_BITS){1'b0}}, phase_step,
                   {pblosc_pkg::PHASE_SHIFT{1'b0}}};

  // 2t - 1 doubles as the naive sawtooth
  assign d      = $signed({{(AB-FB-1){1'b0}}, t_cur, 1'b0}) - ONE_Q32;
  assign d_abs  = d[AB-1] ? -d : d;
  assign tri_v  = (d_abs <<< 1) - ONE_Q32;
  assign sq_v   = t_cur[FB-1] ? -ONE_Q32 : ONE_Q32;
  assign corr_ext = AB'(blep_corr);

  // Q32 to Q15, round half up, then clamp
  assign rounded = v + ROUND_BIAS;
  assign s_wide  = rounded[AB-1:pblosc_pkg::RND_SHIFT];
  assign sat_s   = (s_wide[SW-1] != s_wide[SW-2])
                   ? (s_wide[SW-1] ? SAMPLE_MIN : SAMPLE_MAX)
                   : s_wide[SB-1:0];

  // quarter-wave table: quadrant from the top two phase bits
  assign quad     = cur[PB-1 -: 2];
  assign sidx     = cur[PB-3 -: pblosc_pkg::SINE_IDX_BITS];
  assign saddr    = quad[0]
                    ? pblosc_pkg::SINE_ADDR_BITS'(pblosc_pkg::SINE_DEPTH) - {1'b0, sidx}
                    : {1'b0, sidx};
  assign sval     = pblosc_pkg::SINE_TABLE[saddr];
  assign sine_pos = $signed({{(SB-pblosc_pkg::SINE_VAL_BITS){1'b0}}, sval});
  assign sine_s   = quad[1] ? -sine_pos : sine_pos;

  pblosc_blep u_blep (
    .clk  (clk),
    .rst  (rst),
    .req  (blep_req),
    .dt   (dt),
    .sts  (blep_sts),
    .corr (blep_corr)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pblosc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.ready      = 1'b0;
    blep_req.start = 1'b0;
    blep_req.arg   = blep_arg;
    load_out       = 1'b0;
    unique case (state)
      pblosc_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = pblosc_pkg::S_SETUP;
      end
      pblosc_pkg::S_SETUP: begin
        unique case (waveform)
          pblosc_pkg::WAVE_SINE:   state_next = pblosc_pkg::S_OUT;
          pblosc_pkg::WAVE_TRI:    state_next = pblosc_pkg::S_ROUND;
          pblosc_pkg::WAVE_SAW:    state_next = pblosc_pkg::S_START;
          pblosc_pkg::WAVE_SQUARE: state_next = pblosc_pkg::S_START;
        endcase
      end
      pblosc_pkg::S_START: begin
        blep_req.start = 1'b1;
        state_next     = pblosc_pkg::S_WAIT;
      end
      pblosc_pkg::S_WAIT: begin
        if (blep_sts.done) begin
          state_next = pending ? pblosc_pkg::S_START : pblosc_pkg::S_ROUND;
        end
      end
      pblosc_pkg::S_ROUND: state_next = pblosc_pkg::S_OUT;
      pblosc_pkg::S_OUT: begin
        if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = pblosc_pkg::S_IDLE;
        end
      end
      default: state_next = pblosc_pkg::S_IDLE;
    endcase
  end

  // registers, phase accumulator, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform     <= pblosc_pkg::WAVE_SINE;
      phase_step   <= pblosc_pkg::STEP_BITS'(1);
      phase_acc    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (pblosc_pkg::cfg_reg_t'(cfg_index))
          pblosc_pkg::CFG_WAVEFORM:   waveform   <= pblosc_pkg::wave_t'(cfg_data[1:0]);
          pblosc_pkg::CFG_PHASE_STEP: phase_step <= cfg_data[pblosc_pkg::STEP_BITS-1:0];
        endcase
      end
      if (accept) begin
        phase_acc <= p_sel + {{(PB-pblosc_pkg::STEP_BITS){1'b0}}, phase_step};
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    if (load_out) result.sample <= res;
    unique case (state)
      pblosc_pkg::S_IDLE: begin
        if (accept) cur <= p_sel;
      end
      pblosc_pkg::S_SETUP: begin
        unique case (waveform)
          pblosc_pkg::WAVE_SINE: res <= sine_s;
          pblosc_pkg::WAVE_TRI:  v   <= tri_v;
          pblosc_pkg::WAVE_SAW: begin
            v        <= d;
            blep_arg <= t_cur;
            sub      <= 1'b1;
            pending  <= 1'b0;
          end
          pblosc_pkg::WAVE_SQUARE: begin
            v        <= sq_v;
            blep_arg <= t_cur;
            sub      <= 1'b0;
            pending  <= 1'b1;
          end
        endcase
      end
      pblosc_pkg::S_WAIT: begin
        if (blep_sts.done) begin
          v <= sub ? v - corr_ext : v + corr_ext;
          if (pending) begin
            blep_arg <= ts;
            sub      <= 1'b1;
            pending  <= 1'b0;
          end
        end
      end
      pblosc_pkg::S_ROUND: res <= sat_s;
      default: ;
    endcase
  end

  `PBLOSC_ASSERT_IMPL(a_start_when_free, clk, rst, blep_req.start, !blep_sts.busy)
  `PBLOSC_ASSERT_NEXT(a_accept_starts_work, clk, rst, accept, state == pblosc_pkg::S_SETUP)
  `PBLOSC_ASSERT_NEXT(a_out_loads, clk, rst, load_out, result.valid && state == pblosc_pkg::S_IDLE)

endmodule
